// ===== rtl/core/hscfs_pkg.sv =====
// Package for the H.265 start code frame splitter.
// Shared widths, header codes, frame kinds and the close-event type.
// No dependencies.

package hscfs_pkg;

   // Field widths
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned KIND_W  = 3;
   localparam int unsigned POS_W   = 32;
   localparam int unsigned LEN_W   = 21;
   localparam int unsigned FILL_W  = 3;

   // Frame size limit and the distance at which an open frame is abandoned
   localparam int unsigned MAX_FRAME_BYTES = 1048576;
   localparam logic [POS_W-1:0] MAX_FRAME_LEN = POS_W'(MAX_FRAME_BYTES);
   localparam logic [POS_W-1:0] EXPIRE_DIST   = POS_W'(MAX_FRAME_BYTES + 4);

   // Start code detection
   localparam logic [POS_W-1:0]  START_CODE    = 32'h0000_0001;
   localparam logic [POS_W-1:0]  HISTORY_RESET = 32'hFFFF_FFFF;
   localparam logic [FILL_W-1:0] HISTORY_BYTES = 3'd4;
   localparam logic [POS_W-1:0]  CODE_BYTES    = 32'd4;

   // Header byte values
   localparam logic [BYTE_W-1:0] HDR_IDR = 8'h26;
   localparam logic [BYTE_W-1:0] HDR_P   = 8'h02;
   localparam logic [BYTE_W-1:0] HDR_VPS = 8'h40;
   localparam logic [BYTE_W-1:0] HDR_SPS = 8'h42;
   localparam logic [BYTE_W-1:0] HDR_PPS = 8'h44;
   localparam logic [BYTE_W-1:0] HDR_SEI = 8'h4e;

   // Frame kinds
   localparam logic [KIND_W-1:0] KIND_IDR  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_P    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_VPS  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SPS  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_PPS  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_SEI  = 3'd5;
   localparam logic [KIND_W-1:0] KIND_NONE = 3'd7;

   // Event queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = 1;
   localparam int unsigned QCNT_W      = 2;

   // One frame close: kind and start of the closed frame, offset of the new start code
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [POS_W-1:0]  open_start;
      logic [POS_W-1:0]  code_start;
   } close_event_type;

   // Header byte decoder
   function automatic logic [KIND_W-1:0] header_kind(input logic [BYTE_W-1:0] hdr);
      logic [KIND_W-1:0] kind;
      unique case (hdr)
         HDR_IDR: kind = KIND_IDR;
         HDR_P:   kind = KIND_P;
         HDR_VPS: kind = KIND_VPS;
         HDR_SPS: kind = KIND_SPS;
         HDR_PPS: kind = KIND_PPS;
         HDR_SEI: kind = KIND_SEI;
         default: kind = KIND_NONE;
      endcase
      return kind;
   endfunction

endpackage

// ===== rtl/core/hscfs_if.sv =====
// Channel interfaces for the frame splitter: byte stream in, frame records out.
// Depends on hscfs_pkg.

interface hscfs_req_if;
   logic                              valid;
   logic                              ready;
   logic [hscfs_pkg::BYTE_W-1:0]      data_byte;
   logic                              end_of_stream;

   modport source(output valid, data_byte, end_of_stream, input ready);
   modport sink(input valid, data_byte, end_of_stream, output ready);
endinterface

interface hscfs_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [hscfs_pkg::KIND_W-1:0]      frame_kind;
   logic [hscfs_pkg::POS_W-1:0]       frame_start;
   logic [hscfs_pkg::LEN_W-1:0]       frame_length;

   modport source(output valid, frame_kind, frame_start, frame_length, input ready);
   modport sink(input valid, frame_kind, frame_start, frame_length, output ready);
endinterface

// ===== rtl/core/hevc_start_code_frame_splitter_top.sv =====
// Top level of the H.265 Annex B start code frame splitter.
// Depends on hscfs_pkg, hscfs_if, hscfs_front, hscfs_queue, hscfs_back.
//
//  channel   | direction | payload                                  | handshake
//  ----------+-----------+------------------------------------------+-------------
//  req_bus   | in        | data_byte[7:0], end_of_stream            | valid/ready
//  rsp_bus   | out       | frame_kind[2:0], frame_start[31:0],      | valid/ready
//            |           | frame_length[20:0]                       |
//
// One byte is taken per cycle while the event queue has room. A frame record
// closed by a header byte goes to rsp_bus via event queue, then result register.
// Synchronous active-high reset clears the history, position and queue.
// req_bus stalls only when the two-entry event queue is full; that happens
// only while rsp_bus is held back with a record pending.

module hevc_start_code_frame_splitter_top (
   input  logic        clock,
   input  logic        reset,
   hscfs_req_if.sink   req_bus,
   hscfs_rsp_if.source rsp_bus
);

   logic                       accept;
   logic                       push;
   hscfs_pkg::close_event_type push_event;
   logic                       q_full;
   logic                       pop;
   logic                       head_valid;
   hscfs_pkg::close_event_type head_event;

   assign req_bus.ready = !q_full;
   assign accept        = req_bus.valid && !q_full;

   hscfs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_bus.data_byte),
      .end_of_stream (req_bus.end_of_stream),
      .push          (push),
      .push_event    (push_event)
   );

   hscfs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_event (push_event),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_event (head_event)
   );

   hscfs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_event (head_event),
      .pop        (pop),
      .out_ready  (rsp_bus.ready),
      .out_valid  (rsp_bus.valid),
      .out_kind   (rsp_bus.frame_kind),
      .out_start  (rsp_bus.frame_start),
      .out_length (rsp_bus.frame_length)
   );

   // No close event may arrive while the queue has no room
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !push)
      else $error("close event pushed into a full queue");

   // A record always covers at least a start code and a header byte
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.frame_length >= hscfs_pkg::LEN_W'(5)))
      else $error("frame record shorter than start code plus header");

   // No record right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_bus.valid)
      else $error("record presented right after reset");

   // A popped event needs a queued entry
   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("event taken from an empty queue");

endmodule

// ===== rtl/core/hscfs_front.sv =====
// Front end: byte history, start code detection, header classification and
// open-frame tracking. Emits one close event per frame that a start code ends.
// Depends on hscfs_pkg.

module hscfs_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [hscfs_pkg::BYTE_W-1:0]   data_byte,
   input  logic                           end_of_stream,
   output logic                           push,
   output hscfs_pkg::close_event_type     push_event
);

   logic [hscfs_pkg::POS_W-1:0]  hist_ff, hist_in;
   logic [hscfs_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic [hscfs_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic                         open_ff, open_in;
   logic [hscfs_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [hscfs_pkg::POS_W-1:0]  start_ff, start_in;

   logic                         found;
   logic [hscfs_pkg::KIND_W-1:0] hdr_kind;
   logic [hscfs_pkg::POS_W-1:0]  code_start;
   logic [hscfs_pkg::POS_W-1:0]  open_span;

   // Detection and classification of the current byte
   assign found      = (fill_ff == hscfs_pkg::HISTORY_BYTES) && (hist_ff == hscfs_pkg::START_CODE);
   assign hdr_kind   = hscfs_pkg::header_kind(data_byte);
   assign code_start = pos_ff - hscfs_pkg::CODE_BYTES;
   assign open_span  = pos_ff - start_ff;

   assign push                  = accept && found && open_ff;
   assign push_event.kind       = kind_ff;
   assign push_event.open_start = start_ff;
   assign push_event.code_start = code_start;

   // Next state for one accepted byte
   always_comb begin
      hist_in  = hist_ff;
      fill_in  = fill_ff;
      pos_in   = pos_ff;
      open_in  = open_ff;
      kind_in  = kind_ff;
      start_in = start_ff;
      if (accept) begin
         if (found) begin
            if (hdr_kind != hscfs_pkg::KIND_NONE) begin
               open_in  = 1'b1;
               kind_in  = hdr_kind;
               start_in = code_start;
            end else begin
               open_in = 1'b0;
            end
         end else if (open_ff && (open_span >= hscfs_pkg::EXPIRE_DIST)) begin
            // oversize frame, no valid close possible any more
            open_in = 1'b0;
         end
         hist_in = {hist_ff[hscfs_pkg::POS_W-hscfs_pkg::BYTE_W-1:0], data_byte};
         if (fill_ff != hscfs_pkg::HISTORY_BYTES) begin
            fill_in = fill_ff + 3'd1;
         end
         pos_in = pos_ff + 32'd1;
         if (end_of_stream) begin
            hist_in  = hscfs_pkg::HISTORY_RESET;
            fill_in  = '0;
            pos_in   = '0;
            open_in  = 1'b0;
            kind_in  = '0;
            start_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff  <= hscfs_pkg::HISTORY_RESET;
         fill_ff  <= '0;
         pos_ff   <= '0;
         open_ff  <= 1'b0;
         kind_ff  <= '0;
         start_ff <= '0;
      end else begin
         hist_ff  <= hist_in;
         fill_ff  <= fill_in;
         pos_ff   <= pos_in;
         open_ff  <= open_in;
         kind_ff  <= kind_in;
         start_ff <= start_in;
      end
   end

endmodule

// ===== rtl/core/hscfs_queue.sv =====
// Two-entry event queue between the front and the back of the frame splitter.
// Depends on hscfs_pkg.

module hscfs_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  hscfs_pkg::close_event_type push_event,
   output logic                       full,
   input  logic                       pop,
   output logic                       head_valid,
   output hscfs_pkg::close_event_type head_event
);

   hscfs_pkg::close_event_type   mem_ff [hscfs_pkg::QUEUE_DEPTH];
   logic [hscfs_pkg::QPTR_W-1:0] wr_ff, wr_in;
   logic [hscfs_pkg::QPTR_W-1:0] rd_ff, rd_in;
   logic [hscfs_pkg::QCNT_W-1:0] cnt_ff, cnt_in;

   assign full       = (cnt_ff == hscfs_pkg::QCNT_W'(hscfs_pkg::QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_event = mem_ff[rd_ff];

   // Pointer and count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_event;
      end
   end

endmodule

// ===== rtl/core/hscfs_back.sv =====
// Back end: turns close events into frame records (length, size check)
// and holds the result register toward the response channel.
// Depends on hscfs_pkg.

module hscfs_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           head_valid,
   input  hscfs_pkg::close_event_type     head_event,
   output logic                           pop,
   input  logic                           out_ready,
   output logic                           out_valid,
   output logic [hscfs_pkg::KIND_W-1:0]   out_kind,
   output logic [hscfs_pkg::POS_W-1:0]    out_start,
   output logic [hscfs_pkg::LEN_W-1:0]    out_length
);

   logic                         valid_ff, valid_in;
   logic [hscfs_pkg::KIND_W-1:0] kind_ff;
   logic [hscfs_pkg::POS_W-1:0]  start_ff;
   logic [hscfs_pkg::LEN_W-1:0]  length_ff;
   logic [hscfs_pkg::POS_W-1:0]  len;
   logic                         len_ok;

   // Length of the closed frame, start code included
   assign len    = head_event.code_start - head_event.open_start;
   assign len_ok = (len <= hscfs_pkg::MAX_FRAME_LEN);

   // Take an event whenever the result register is free or draining
   assign pop = head_valid && (!valid_ff || out_ready);

   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && out_ready) begin
         valid_in = 1'b0;
      end
      if (pop && len_ok) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (pop && len_ok) begin
         kind_ff   <= head_event.kind;
         start_ff  <= head_event.open_start;
         length_ff <= len[hscfs_pkg::LEN_W-1:0];
      end
   end

   assign out_valid  = valid_ff;
   assign out_kind   = kind_ff;
   assign out_start  = start_ff;
   assign out_length = length_ff;

endmodule
